### rtl/sphere_frustum_cull_test_core_macros.svh
// Assertion macros shared by the sphere frustum cull checker.
`ifndef SPHERE_FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_TEST_CORE_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define SFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfc checker: same-cycle property failed");

// Next-cycle implication, inactive while reset is asserted.
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfc checker: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define SFC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfc checker: reset property failed");

`endif

### rtl/sfc_pkg.sv
// Shared constants and types for the sphere frustum cull test.
`timescale 1ns / 1ps

package sfc_pkg;

  // Geometry of the plane store and the operand formats.
  localparam int NUM_PLANES  = 4;
  localparam int COORD_WIDTH = 32;
  localparam int NORM_WIDTH  = 16;
  localparam int NORM_FRAC   = 15;
  localparam int IDX_WIDTH   = 2;

  // Datapath widths: one product, the offset plus radius, and the full distance.
  localparam int PROD_WIDTH  = NORM_WIDTH + COORD_WIDTH;
  localparam int BIAS_WIDTH  = COORD_WIDTH + 1;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;

  // Item operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // One stored side plane.
  typedef struct packed {
    logic [NORM_WIDTH-1:0]  nx;
    logic [NORM_WIDTH-1:0]  ny;
    logic [NORM_WIDTH-1:0]  nz;
    logic [COORD_WIDTH-1:0] offset;
  } plane_t;

endpackage

### rtl/sfc_if.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps

interface sfc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic [sfc_pkg::IDX_WIDTH-1:0]           plane_index;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]   normal_x;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]   normal_y;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]   normal_z;
  logic signed [sfc_pkg::COORD_WIDTH-1:0]  plane_offset;
  logic signed [sfc_pkg::COORD_WIDTH-1:0]  center_x;
  logic signed [sfc_pkg::COORD_WIDTH-1:0]  center_y;
  logic signed [sfc_pkg::COORD_WIDTH-1:0]  center_z;
  logic [sfc_pkg::COORD_WIDTH-2:0]         radius;

  modport source (
    output valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
           center_x, center_y, center_z, radius,
    input  ready
  );

  modport sink (
    input  valid, op, plane_index, normal_x, normal_y, normal_z, plane_offset,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

interface sfc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

### rtl/sfc_plane_dist.sv
// Two-stage signed distance of a sphere against one plane, widened by the radius.
`timescale 1ns / 1ps

module sfc_plane_dist (
  input  logic                                   clk,
  input  logic                                   en,
  input  sfc_pkg::plane_t                        plane_i,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] cx_i,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] cy_i,
  input  logic signed [sfc_pkg::COORD_WIDTH-1:0] cz_i,
  input  logic [sfc_pkg::COORD_WIDTH-2:0]        radius_i,
  output logic                                   reach_ok_o
);

  logic signed [sfc_pkg::PROD_WIDTH-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [sfc_pkg::PROD_WIDTH-1:0] px_r, py_r, pz_r;
  logic signed [sfc_pkg::BIAS_WIDTH-1:0] bias_nxt, bias_r;
  logic signed [sfc_pkg::SUM_WIDTH-1:0]  sa_nxt, sb_nxt, sa_r, sb_r, total;

  // Products of the normal and the center, and the offset plus the radius.
  always_comb begin
    px_nxt   = $signed(plane_i.nx) * cx_i;
    py_nxt   = $signed(plane_i.ny) * cy_i;
    pz_nxt   = $signed(plane_i.nz) * cz_i;
    bias_nxt = $signed({plane_i.offset[sfc_pkg::COORD_WIDTH-1], plane_i.offset})
             + $signed({2'b00, radius_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      bias_r <= bias_nxt;
    end
  end

  // Pairwise partial sums; the offset and radius move to the product scale.
  always_comb begin
    sa_nxt = sfc_pkg::SUM_WIDTH'(px_r) + sfc_pkg::SUM_WIDTH'(py_r);
    sb_nxt = sfc_pkg::SUM_WIDTH'(pz_r)
           + (sfc_pkg::SUM_WIDTH'(bias_r) <<< sfc_pkg::NORM_FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
  end

  // The sphere reaches the inner side when distance plus radius is not negative.
  assign total      = sa_r + sb_r;
  assign reach_ok_o = ~total[sfc_pkg::SUM_WIDTH-1];

endmodule

### rtl/sphere_frustum_cull_test_core.sv
// Top level of the sphere-against-frustum-sides culling test.
//
// Usage:
//   in_ch carries one item per valid/ready handshake. A load item (op = load)
//   writes the normal and offset of plane plane_index; an index beyond the
//   plane count is dropped. A test item (op = test) gives a sphere center and
//   radius and yields exactly one result item on out_ch; a load yields none.
//   out_ch.visible is 1 when the sphere touches or lies inside all side planes.
//   Throughput is one item per cycle while out_ch does not stall. A test item
//   passes an input register, a product stage of twelve 16x32 multipliers, a
//   partial-sum stage and the output register on its way to out_ch. Loads take
//   effect in item order, so a test right after a load already sees the new
//   plane.
//   When out_ch stalls with a result waiting, the whole pipeline holds and
//   in_ch.ready drops; nothing is lost or repeated. in_ch.ready is high
//   whenever the output register is empty or being drained.
//   Reset (rst_n low, synchronous) empties the pipeline and clears every
//   plane to zero normals and zero offset; such planes reject nothing.
`timescale 1ns / 1ps

module sphere_frustum_cull_test_core (
  input  logic      clk,
  input  logic      rst_n,
  sfc_in_if.sink    in_ch,
  sfc_out_if.source out_ch
);

  logic adv;

  // Input stage.
  logic                                   s1_valid_r;
  logic                                   s1_op_r;
  logic [sfc_pkg::IDX_WIDTH-1:0]          s1_idx_r;
  sfc_pkg::plane_t                        s1_plane_r;
  logic signed [sfc_pkg::COORD_WIDTH-1:0] s1_cx_r, s1_cy_r, s1_cz_r;
  logic [sfc_pkg::COORD_WIDTH-2:0]        s1_rad_r;

  // Later stages only carry valid bits; the data sits in the plane units.
  logic s2_valid_r, s3_valid_r, out_valid_r, visible_r;
  logic s2_valid_nxt;

  sfc_pkg::plane_t                 planes_r [sfc_pkg::NUM_PLANES];
  logic [sfc_pkg::NUM_PLANES-1:0]  reach_ok;

  // The pipeline moves whenever the output register can take a new item.
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.visible = visible_r;

  // Register the accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_ch.op;
      s1_idx_r   <= in_ch.plane_index;
      s1_plane_r <= '{nx: in_ch.normal_x, ny: in_ch.normal_y, nz: in_ch.normal_z,
                      offset: in_ch.plane_offset};
      s1_cx_r    <= in_ch.center_x;
      s1_cy_r    <= in_ch.center_y;
      s1_cz_r    <= in_ch.center_z;
      s1_rad_r   <= in_ch.radius;
    end
  end

  // Plane store: a load writes as it leaves the input stage, after all
  // earlier tests have read the planes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) begin
        planes_r[i] <= '0;
      end
    end else if (adv && s1_valid_r && (s1_op_r == sfc_pkg::OP_LOAD)) begin
      for (int i = 0; i < sfc_pkg::NUM_PLANES; i++) begin
        if (32'(s1_idx_r) == 32'(i)) begin
          planes_r[i] <= s1_plane_r;
        end
      end
    end
  end

  // One distance unit per plane, all fed by the same sphere.
  for (genvar p = 0; p < sfc_pkg::NUM_PLANES; p++) begin : g_plane
    sfc_plane_dist u_dist (
      .clk        (clk),
      .en         (adv),
      .plane_i    (planes_r[p]),
      .cx_i       (s1_cx_r),
      .cy_i       (s1_cy_r),
      .cz_i       (s1_cz_r),
      .radius_i   (s1_rad_r),
      .reach_ok_o (reach_ok[p])
    );
  end

  // Valid bits follow test items through the product and sum stages.
  assign s2_valid_nxt = s1_valid_r && (s1_op_r == sfc_pkg::OP_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Visible only if the sphere reaches the inner side of every plane.
  always_ff @(posedge clk) begin
    if (adv) begin
      visible_r <= &reach_ok;
    end
  end

endmodule

### rtl/sfc_checker.sv
// Port-level checker for the sphere frustum cull test, bound to the top level.
`timescale 1ns / 1ps
`include "sphere_frustum_cull_test_core_macros.svh"

module sfc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible
);

  // The input side is never blocked while the output register is empty.
  `SFC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // While a result is held back, no new item may enter.
  `SFC_ASSERT_NOW(a_block_on_stall, out_valid && !out_ready, !in_ready)

  // A stalled result stays in place with the same value.
  `SFC_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready,
                   out_valid && $stable(out_visible))

  // Reset empties the result register.
  `SFC_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind sphere_frustum_cull_test_core sfc_checker u_sfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_visible (out_ch.visible)
);

### sim/sphere_frustum_cull_test_core_tb.sv
// Self-checking testbench for the sphere frustum cull test core.
`timescale 1ns / 1ps

// One item as it travels on the input channel.
typedef struct {
  logic                                   op;
  logic [sfc_pkg::IDX_WIDTH-1:0]          plane_index;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]  normal_x;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]  normal_y;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]  normal_z;
  logic signed [sfc_pkg::COORD_WIDTH-1:0] plane_offset;
  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_x;
  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_y;
  logic signed [sfc_pkg::COORD_WIDTH-1:0] center_z;
  logic [sfc_pkg::COORD_WIDTH-2:0]        radius;
} sphere_item_t;

// Keeps a private copy of the plane store and the queue of pending visibility flags.
class cull_scoreboard;
  logic signed [sfc_pkg::NORM_WIDTH-1:0]  nrm_x [sfc_pkg::NUM_PLANES];
  logic signed [sfc_pkg::NORM_WIDTH-1:0]  nrm_y [sfc_pkg::NUM_PLANES];
  logic signed [sfc_pkg::NORM_WIDTH-1:0]  nrm_z [sfc_pkg::NUM_PLANES];
  logic signed [sfc_pkg::COORD_WIDTH-1:0] offsets [sfc_pkg::NUM_PLANES];
  logic                                   visible_expected [$];
  int unsigned                            fails;

  // Reset state: every plane holds zero normals and a zero offset.
  function new();
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      nrm_x[p]   = '0;
      nrm_y[p]   = '0;
      nrm_z[p]   = '0;
      offsets[p] = '0;
    end
    fails = 0;
  endfunction

  // Exact signed distances to each plane; the sum fits easily in 64 bits.
  function logic predict_visible(sphere_item_t it);
    longint dist_sum;
    longint reach;
    bit     all_inside;
    bit     all_touch;
    all_inside = 1'b1;
    all_touch  = 1'b1;
    for (int p = 0; p < sfc_pkg::NUM_PLANES; p++) begin
      dist_sum = longint'(nrm_x[p]) * longint'(it.center_x)
               + longint'(nrm_y[p]) * longint'(it.center_y)
               + longint'(nrm_z[p]) * longint'(it.center_z)
               + longint'(offsets[p]) * 64'sd32768;
      reach = dist_sum + longint'(it.radius) * 64'sd32768;
      if (dist_sum < 0) all_inside = 1'b0;
      if (reach < 0) all_touch = 1'b0;
    end
    return all_inside || all_touch;
  endfunction

  // A load updates the plane store in order; a test queues one visibility flag.
  function void note_item(sphere_item_t it);
    if (it.op == sfc_pkg::OP_LOAD) begin
      if (int'(it.plane_index) < sfc_pkg::NUM_PLANES) begin
        nrm_x[it.plane_index]   = it.normal_x;
        nrm_y[it.plane_index]   = it.normal_y;
        nrm_z[it.plane_index]   = it.normal_z;
        offsets[it.plane_index] = it.plane_offset;
      end
    end else begin
      visible_expected = {visible_expected, predict_visible(it)};
    end
  endfunction

  function void check_visible(logic got);
    logic want;
    if (visible_expected.size() == 0) begin
      $error("visible: result item arrived with nothing expected (actual %0b)", got);
      fails++;
    end else begin
      want = visible_expected.pop_front();
      if (got !== want) begin
        $error("visible mismatch: expected %0b, actual %0b", want, got);
        fails++;
      end
    end
  endfunction

  function int pending();
    return visible_expected.size();
  endfunction
endclass

module sphere_frustum_cull_test_core_tb;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT    = 11;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 20;
  localparam int DRAIN_LIMIT = 2000;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;

  sfc_in_if  in_ch ();
  sfc_out_if out_ch ();

  cull_scoreboard sb = new();

  int unsigned gap_pct = IDLE_PCT;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  sphere_frustum_cull_test_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Both handshakes are observed at the rising edge: results are checked, inputs predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_visible(out_ch.visible);
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item('{op: in_ch.op, plane_index: in_ch.plane_index,
                       normal_x: in_ch.normal_x, normal_y: in_ch.normal_y,
                       normal_z: in_ch.normal_z, plane_offset: in_ch.plane_offset,
                       center_x: in_ch.center_x, center_y: in_ch.center_y,
                       center_z: in_ch.center_z, radius: in_ch.radius});
      end
    end
  end

  // Result receiver: random back-pressure, plus one long hold when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= gap_pct);
      end
    end
  end

  function automatic sphere_item_t load_item(
      logic [sfc_pkg::IDX_WIDTH-1:0]          idx,
      logic signed [sfc_pkg::NORM_WIDTH-1:0]  nx,
      logic signed [sfc_pkg::NORM_WIDTH-1:0]  ny,
      logic signed [sfc_pkg::NORM_WIDTH-1:0]  nz,
      logic signed [sfc_pkg::COORD_WIDTH-1:0] off);
    sphere_item_t it;
    it = '{op: sfc_pkg::OP_LOAD, plane_index: idx, normal_x: nx, normal_y: ny,
           normal_z: nz, plane_offset: off, center_x: $urandom, center_y: $urandom,
           center_z: $urandom, radius: (sfc_pkg::COORD_WIDTH - 1)'($urandom)};
    return it;
  endfunction

  function automatic sphere_item_t test_item(
      logic signed [sfc_pkg::COORD_WIDTH-1:0] cx,
      logic signed [sfc_pkg::COORD_WIDTH-1:0] cy,
      logic signed [sfc_pkg::COORD_WIDTH-1:0] cz,
      logic [sfc_pkg::COORD_WIDTH-2:0]        r);
    sphere_item_t it;
    it = '{op: sfc_pkg::OP_TEST, plane_index: sfc_pkg::IDX_WIDTH'($urandom),
           normal_x: sfc_pkg::NORM_WIDTH'($urandom),
           normal_y: sfc_pkg::NORM_WIDTH'($urandom),
           normal_z: sfc_pkg::NORM_WIDTH'($urandom),
           plane_offset: $urandom, center_x: cx, center_y: cy,
           center_z: cz, radius: r};
    return it;
  endfunction

  // Signed value spread over roughly plus or minus 2**span.
  function automatic logic signed [sfc_pkg::COORD_WIDTH-1:0] near_value(int span);
    return int'($urandom) >>> (31 - span);
  endfunction

  // Mostly scene-like items of moderate size, so that both verdicts occur often;
  // the rest use the full range of every field.
  function automatic sphere_item_t random_item();
    bit           full_range;
    bit           is_load;
    sphere_item_t it;
    full_range = ($urandom_range(99) < 25);
    is_load    = ($urandom_range(99) < 20);
    if (full_range) begin
      if (is_load) begin
        it = load_item(sfc_pkg::IDX_WIDTH'($urandom), sfc_pkg::NORM_WIDTH'($urandom),
                       sfc_pkg::NORM_WIDTH'($urandom), sfc_pkg::NORM_WIDTH'($urandom),
                       $urandom);
      end else begin
        it = test_item($urandom, $urandom, $urandom,
                       (sfc_pkg::COORD_WIDTH - 1)'($urandom));
      end
    end else if (is_load) begin
      // Now and then a plane is cleared, which makes it accept every sphere.
      if ($urandom_range(9) == 0) begin
        it = load_item(sfc_pkg::IDX_WIDTH'($urandom), '0, '0, '0, '0);
      end else begin
        it = load_item(sfc_pkg::IDX_WIDTH'($urandom),
                       sfc_pkg::NORM_WIDTH'(near_value(14)),
                       sfc_pkg::NORM_WIDTH'(near_value(14)),
                       sfc_pkg::NORM_WIDTH'(near_value(14)),
                       near_value(22));
      end
    end else begin
      it = test_item(near_value(22), near_value(22), near_value(22),
                     ($urandom_range(3) == 0) ? '0 :
                     (sfc_pkg::COORD_WIDTH - 1)'($urandom_range(0, 1 << 23)));
    end
    return it;
  endfunction

  // Offer one item at the falling edge and hold it until the block takes it.
  task automatic drive_item(sphere_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= it.op;
    in_ch.plane_index  <= it.plane_index;
    in_ch.normal_x     <= it.normal_x;
    in_ch.normal_y     <= it.normal_y;
    in_ch.normal_z     <= it.normal_z;
    in_ch.plane_offset <= it.plane_offset;
    in_ch.center_x     <= it.center_x;
    in_ch.center_y     <= it.center_y;
    in_ch.center_z     <= it.center_z;
    in_ch.radius       <= it.radius;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drive_random(int count);
    for (int k = 0; k < count; k++) drive_item(random_item());
  endtask

  // The sender stops until every pending result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int wait_cycles;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = sfc_pkg::OP_LOAD;
    in_ch.plane_index  = '0;
    in_ch.normal_x     = '0;
    in_ch.normal_y     = '0;
    in_ch.normal_z     = '0;
    in_ch.plane_offset = '0;
    in_ch.center_x     = '0;
    in_ch.center_y     = '0;
    in_ch.center_z     = '0;
    in_ch.radius       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Planes never loaded are all zero and must accept any sphere.
    drive_item(test_item(32'sh7fffffff, 32'sh80000000, '0, '0));
    drive_item(test_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff));

    // Half-length normal along x: the center on the plane, just outside, and just touching.
    drive_item(load_item(2'd0, 16'sd16384, '0, '0, '0));
    drive_item(test_item('0, 32'sd5, -32'sd9, '0));
    drive_item(test_item(-32'sd2, '0, '0, '0));
    drive_item(test_item(-32'sd2, '0, '0, 31'd1));
    drive_item(test_item(-32'sd3, '0, '0, 31'd1));

    // Extreme and non-unit normals with extreme offsets in the other planes.
    drive_item(load_item(2'd1, -16'sd32768, 16'sd32767, 16'sd32767, 32'sh7fffffff));
    drive_item(load_item(2'd2, '0, -16'sd32768, '0, 32'sh80000000));
    drive_item(load_item(2'd3, 16'sd32767, 16'sd32767, -16'sd32768, -32'sd1));
    drive_item(test_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff));
    drive_item(test_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000, '0));
    drive_item(test_item('0, '0, '0, '0));
    drive_item(test_item(-32'sd1, -32'sd1, -32'sd1, 31'd1));
    drive_item(test_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff));
    drive_item(test_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff));

    // A load followed at once by a test must see the new plane.
    drive_item(load_item(2'd2, '0, '0, '0, -32'sd1));
    drive_item(test_item('0, '0, '0, '0));
    drive_item(test_item('0, '0, '0, 31'd1));
    drive_item(load_item(2'd2, '0, '0, '0, '0));
    drive_item(load_item(2'd1, '0, '0, '0, '0));
    drive_item(load_item(2'd3, '0, '0, '0, '0));
    drive_item(test_item(-32'sd1, '0, '0, '0));
    drive_item(test_item(32'sd1, '0, '0, '0));
    wait_drained();

    // Random traffic with random gaps on both sides.
    drive_random(500);

    // A stretch with no idling on either side.
    gap_pct = 0;
    drive_random(300);
    gap_pct = IDLE_PCT;

    // The receiver holds off while the sender keeps offering, so the pipeline fills.
    hold_request = 1'b1;
    drive_random(40);
    wait_drained();

    drive_random(460);

    // Let the last results drain, then allow stray extra results to show up.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("visible: %0d expected result items never arrived", sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
